### rtl/vec3_normalize_assert.svh
// Assertion macros for the vector normaliser.
// Each macro takes a label and a property expression, clocked on clk.
`ifndef VEC3_NORMALIZE_ASSERT_SVH
`define VEC3_NORMALIZE_ASSERT_SVH
`ifndef ASSERT_OFF
`define VN_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("vec3_normalize assertion failed");
`define VN_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("vec3_normalize assertion failed");
`else
`define VN_ASSERT(label, prop)
`define VN_ASSERT_ALWAYS(label, prop)
`endif
`endif

### rtl/vn_pkg.sv
`timescale 1ns / 1ps

package vn_pkg;

  // Fixed-point formats.
  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 24;
  localparam int UNIT_W    = FRAC_BITS + 2;
  localparam int MAG_W     = 32;
  // Magnitude of one vector component, up to 2^31.
  localparam int CMAG_W    = 32;
  // Sum of squares.
  localparam int SUM_W     = 2 * CMAG_W;
  // Square root iterations, one result bit each.
  localparam int SQ_STEPS  = SUM_W / 2;
  // Quotient bits of a unit component (0 .. 2^F).
  localparam int Q_W       = FRAC_BITS + 1;
  // Dividend of a unit component: mag * 2^F + m / 2.
  localparam int NUM_W     = CMAG_W + FRAC_BITS + 1;

  // Per-item data that travels alongside the arithmetic.
  typedef struct packed {
    logic                   zero;
    logic [2:0]             neg;
    logic [2:0][CMAG_W-1:0] mag;
  } side_t;

endpackage

### rtl/vn_cross.sv
`timescale 1ns / 1ps

// Forms the vector to normalise: a itself or the rounded, clamped a x b.
// Two register stages: products, then difference, rounding and magnitude.
module vn_cross (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              vld_i,
  input  logic                              mode_i,
  input  logic signed [vn_pkg::IN_W-1:0]    ax_i,
  input  logic signed [vn_pkg::IN_W-1:0]    ay_i,
  input  logic signed [vn_pkg::IN_W-1:0]    az_i,
  input  logic signed [vn_pkg::IN_W-1:0]    bx_i,
  input  logic signed [vn_pkg::IN_W-1:0]    by_i,
  input  logic signed [vn_pkg::IN_W-1:0]    bz_i,
  output logic                              vld_o,
  output vn_pkg::side_t                     side_o
);

  localparam int P_W = 2 * vn_pkg::IN_W;
  localparam int D_W = P_W + 2;
  localparam logic signed [D_W-1:0] HALF  = D_W'(64'sd1 <<< (vn_pkg::FRAC_BITS - 1));
  localparam logic signed [D_W-1:0] LIM_P = D_W'(64'sd1 <<< (vn_pkg::CMAG_W - 1));
  localparam logic signed [D_W-1:0] LIM_N = -LIM_P;

  logic                          vld1_r;
  logic                          mode_r;
  logic signed [P_W-1:0]         prod_r [0:5];
  logic signed [vn_pkg::IN_W-1:0] a_r   [0:2];
  logic                          vld2_r;
  vn_pkg::side_t                 side_r;
  vn_pkg::side_t                 side_nxt;

  // Stage one: the six partial products of the cross product.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode_r    <= mode_i;
      prod_r[0] <= ay_i * bz_i;
      prod_r[1] <= az_i * by_i;
      prod_r[2] <= az_i * bx_i;
      prod_r[3] <= ax_i * bz_i;
      prod_r[4] <= ax_i * by_i;
      prod_r[5] <= ay_i * bx_i;
      a_r[0]    <= ax_i;
      a_r[1]    <= ay_i;
      a_r[2]    <= az_i;
    end
  end

  // Stage two: difference, round half up, clamp, then sign and magnitude.
  always_comb begin
    logic signed [D_W-1:0] diff;
    logic signed [D_W-1:0] rnd;
    logic signed [D_W-1:0] cv;
    logic signed [D_W-1:0] av;
    side_nxt      = '0;
    for (int k = 0; k < 3; k++) begin
      diff = D_W'(prod_r[2*k]) - D_W'(prod_r[2*k+1]);
      rnd  = (diff + HALF) >>> vn_pkg::FRAC_BITS;
      if (rnd > LIM_P) begin
        rnd = LIM_P;
      end else if (rnd < LIM_N) begin
        rnd = LIM_N;
      end
      cv = mode_r ? rnd : D_W'(a_r[k]);
      av = cv[D_W-1] ? -cv : cv;
      side_nxt.neg[k] = cv[D_W-1];
      side_nxt.mag[k] = av[vn_pkg::CMAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (en) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_nxt;
    end
  end

  assign vld_o  = vld2_r;
  assign side_o = side_r;

endmodule

### rtl/vn_sumsq.sv
`timescale 1ns / 1ps

// Sum of squares of the three component magnitudes, and the zero test.
// Two register stages: squares, then sum.
module vn_sumsq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_i,
  input  vn_pkg::side_t               side_i,
  output logic                        vld_o,
  output logic [vn_pkg::SUM_W-1:0]    sum_o,
  output vn_pkg::side_t               side_o
);

  logic                       vld1_r;
  logic [vn_pkg::SUM_W-1:0]   sq_r [0:2];
  vn_pkg::side_t              side1_r;
  logic                       vld2_r;
  logic [vn_pkg::SUM_W-1:0]   sum_r;
  logic [vn_pkg::SUM_W-1:0]   sum_nxt;
  vn_pkg::side_t              side2_r;
  vn_pkg::side_t              side2_nxt;

  // Stage one: one square per component.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= side_i.mag[k] * side_i.mag[k];
      end
      side1_r <= side_i;
    end
  end

  // Stage two: the sum cannot overflow, as each magnitude is at most 2^31.
  always_comb begin
    sum_nxt        = sq_r[0] + sq_r[1] + sq_r[2];
    side2_nxt      = side1_r;
    side2_nxt.zero = (sum_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r   <= sum_nxt;
      side2_r <= side2_nxt;
    end
  end

  assign vld_o  = vld2_r;
  assign sum_o  = sum_r;
  assign side_o = side2_r;

endmodule

### rtl/vn_sqrt.sv
`timescale 1ns / 1ps

// Pipelined digit-by-digit square root, one result bit per stage,
// followed by a stage that rounds to nearest and saturates.
module vn_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_i,
  input  logic [vn_pkg::SUM_W-1:0]    sum_i,
  input  vn_pkg::side_t               side_i,
  output logic                        vld_o,
  output logic [vn_pkg::MAG_W-1:0]    mag_o,
  output vn_pkg::side_t               side_o
);

  localparam int N = vn_pkg::SQ_STEPS;

  logic                       vld_r  [0:N-1];
  logic [vn_pkg::SUM_W-1:0]   s_r    [0:N-1];
  logic [vn_pkg::SUM_W-1:0]   res_r  [0:N-1];
  vn_pkg::side_t              side_r [0:N-1];

  logic                       vldf_r;
  logic [vn_pkg::MAG_W-1:0]   mag_r;
  logic [vn_pkg::MAG_W-1:0]   mag_nxt;
  vn_pkg::side_t              sidef_r;

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic [vn_pkg::SUM_W-1:0] BIT =
      vn_pkg::SUM_W'(1) << (vn_pkg::SUM_W - 2 - 2 * i);
    logic                     vld_cur;
    logic [vn_pkg::SUM_W-1:0] s_cur;
    logic [vn_pkg::SUM_W-1:0] res_cur;
    vn_pkg::side_t            side_cur;
    logic [vn_pkg::SUM_W-1:0] trial;
    logic [vn_pkg::SUM_W-1:0] s_nxt;
    logic [vn_pkg::SUM_W-1:0] res_nxt;

    if (i == 0) begin : g_first
      assign vld_cur  = vld_i;
      assign s_cur    = sum_i;
      assign res_cur  = '0;
      assign side_cur = side_i;
    end else begin : g_next
      assign vld_cur  = vld_r[i-1];
      assign s_cur    = s_r[i-1];
      assign res_cur  = res_r[i-1];
      assign side_cur = side_r[i-1];
    end

    // Try the current bit: subtract where the remainder allows it.
    always_comb begin
      trial = res_cur + BIT;
      if (s_cur >= trial) begin
        s_nxt   = s_cur - trial;
        res_nxt = (res_cur >> 1) + BIT;
      end else begin
        s_nxt   = s_cur;
        res_nxt = res_cur >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[i]    <= s_nxt;
        res_r[i]  <= res_nxt;
        side_r[i] <= side_cur;
      end
    end
  end

  // Round to nearest and saturate to the output width.
  always_comb begin
    logic [vn_pkg::SUM_W-1:0] rounded;
    rounded = (s_r[N-1] > res_r[N-1]) ? res_r[N-1] + 1'b1 : res_r[N-1];
    if (rounded > vn_pkg::SUM_W'({vn_pkg::MAG_W{1'b1}})) begin
      mag_nxt = '1;
    end else begin
      mag_nxt = rounded[vn_pkg::MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldf_r <= 1'b0;
    end else if (en) begin
      vldf_r <= vld_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r   <= mag_nxt;
      sidef_r <= side_r[N-1];
    end
  end

  assign vld_o  = vldf_r;
  assign mag_o  = mag_r;
  assign side_o = sidef_r;

endmodule

### rtl/vn_div.sv
`timescale 1ns / 1ps

// Three pipelined restoring dividers that share the divisor: each forms
// round(mag * 2^F / m). One set-up stage, then one quotient bit per stage.
module vn_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              vld_i,
  input  logic [vn_pkg::MAG_W-1:0]          mag_i,
  input  vn_pkg::side_t                     side_i,
  output logic                              vld_o,
  output logic [2:0][vn_pkg::Q_W-1:0]       q_o,
  output logic [vn_pkg::MAG_W-1:0]          mag_o,
  output vn_pkg::side_t                     side_o
);

  localparam int N  = vn_pkg::Q_W;
  localparam int RW = vn_pkg::MAG_W;

  // Index 0 is the set-up stage, indexes 1 to N the quotient bits.
  logic                         vld_r  [0:N];
  logic [2:0][RW-1:0]           rem_r  [0:N];
  logic [2:0][N-1:0]            low_r  [0:N];
  logic [2:0][N-1:0]            q_r    [0:N];
  logic [RW-1:0]                m_r    [0:N];
  vn_pkg::side_t                side_r [0:N];

  logic [2:0][RW-1:0]           rem0_nxt;
  logic [2:0][N-1:0]            low0_nxt;

  // Set-up: the dividend carries half the divisor for rounding. Its
  // quotient stays below 2^(F+1), so the upper part starts below m.
  always_comb begin
    logic [vn_pkg::NUM_W-1:0] num;
    for (int k = 0; k < 3; k++) begin
      num = vn_pkg::NUM_W'({side_i.mag[k], {vn_pkg::FRAC_BITS{1'b0}}})
          + vn_pkg::NUM_W'(mag_i >> 1);
      rem0_nxt[k] = num[vn_pkg::NUM_W-1:N];
      low0_nxt[k] = num[N-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= rem0_nxt;
      low_r[0]  <= low0_nxt;
      q_r[0]    <= '0;
      m_r[0]    <= mag_i;
      side_r[0] <= side_i;
    end
  end

  for (genvar i = 1; i <= N; i++) begin : g_bit
    logic [2:0][RW-1:0] rem_nxt;
    logic [2:0][N-1:0]  low_nxt;
    logic [2:0][N-1:0]  q_nxt;

    // Bring down the next dividend bit and subtract where it fits.
    always_comb begin
      logic [RW:0] t;
      logic [RW:0] d;
      logic        ge;
      for (int k = 0; k < 3; k++) begin
        t  = {rem_r[i-1][k], low_r[i-1][k][N-1]};
        ge = (t >= {1'b0, m_r[i-1]});
        d  = t - {1'b0, m_r[i-1]};
        rem_nxt[k] = ge ? d[RW-1:0] : t[RW-1:0];
        low_nxt[k] = {low_r[i-1][k][N-2:0], 1'b0};
        q_nxt[k]   = {q_r[i-1][k][N-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        low_r[i]  <= low_nxt;
        q_r[i]    <= q_nxt;
        m_r[i]    <= m_r[i-1];
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign vld_o  = vld_r[N];
  assign q_o    = q_r[N];
  assign mag_o  = m_r[N];
  assign side_o = side_r[N];

endmodule

### rtl/vec3_normalize.sv
`timescale 1ns / 1ps
`include "vec3_normalize_assert.svh"

// Channel  Direction  Contents
// in_      slave      tdata: ax, ay, az, bx, by, bz; tuser: req_type
// out_     master     tdata: unit_x, unit_y, unit_z, magnitude; tuser: zero_length
//
// One item enters per cycle unless the output stalls; results leave in order.
// Most of the latency is the square root, one result bit per stage over 32
// stages, and the divider, one quotient bit per stage over 17 stages.
// Reset clears only the valid bits of the pipeline; no item is in flight after.
// A stall on the output freezes the whole pipeline, output register included.
module vec3_normalize (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // ax [23:0], ay [47:24], az [71:48], bx [95:72], by [119:96], bz [143:120]
  input  logic [143:0] in_tdata,
  // req_type [0]
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // unit_x [17:0], unit_y [35:18], unit_z [53:36], magnitude [85:54], zero pad
  output logic [87:0]  out_tdata,
  // zero_length [0]
  output logic         out_tuser
);

  localparam int IW = vn_pkg::IN_W;
  localparam int UW = vn_pkg::UNIT_W;
  localparam logic [vn_pkg::Q_W-1:0] ONE = vn_pkg::Q_W'(1) << vn_pkg::FRAC_BITS;

  logic                              en;
  logic                              cr_vld;
  vn_pkg::side_t                     cr_side;
  logic                              ss_vld;
  logic [vn_pkg::SUM_W-1:0]          ss_sum;
  vn_pkg::side_t                     ss_side;
  logic                              sq_vld;
  logic [vn_pkg::MAG_W-1:0]          sq_mag;
  vn_pkg::side_t                     sq_side;
  logic                              dv_vld;
  logic [2:0][vn_pkg::Q_W-1:0]       dv_q;
  logic [vn_pkg::MAG_W-1:0]          dv_mag;
  vn_pkg::side_t                     dv_side;

  logic                              out_valid_r;
  logic [2:0][UW-1:0]                unit_r;
  logic [2:0][UW-1:0]                unit_nxt;
  logic [vn_pkg::MAG_W-1:0]          mag_r;
  logic                              zero_r;

  // The pipeline moves whenever the output register is free or being taken.
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  vn_cross u_cross (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_tvalid),
    .mode_i (in_tuser),
    .ax_i   ($signed(in_tdata[IW-1:0])),
    .ay_i   ($signed(in_tdata[2*IW-1:IW])),
    .az_i   ($signed(in_tdata[3*IW-1:2*IW])),
    .bx_i   ($signed(in_tdata[4*IW-1:3*IW])),
    .by_i   ($signed(in_tdata[5*IW-1:4*IW])),
    .bz_i   ($signed(in_tdata[6*IW-1:5*IW])),
    .vld_o  (cr_vld),
    .side_o (cr_side)
  );

  vn_sumsq u_sumsq (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (cr_vld),
    .side_i (cr_side),
    .vld_o  (ss_vld),
    .sum_o  (ss_sum),
    .side_o (ss_side)
  );

  vn_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (ss_vld),
    .sum_i  (ss_sum),
    .side_i (ss_side),
    .vld_o  (sq_vld),
    .mag_o  (sq_mag),
    .side_o (sq_side)
  );

  vn_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (sq_vld),
    .mag_i  (sq_mag),
    .side_i (sq_side),
    .vld_o  (dv_vld),
    .q_o    (dv_q),
    .mag_o  (dv_mag),
    .side_o (dv_side)
  );

  // Saturate each quotient at 1.0, restore the sign, and zero the vector
  // when the length is zero.
  always_comb begin
    logic [vn_pkg::Q_W-1:0] qc;
    logic [UW-1:0]          pos;
    for (int k = 0; k < 3; k++) begin
      qc  = (dv_q[k] > ONE) ? ONE : dv_q[k];
      pos = UW'(qc);
      if (dv_side.zero) begin
        unit_nxt[k] = '0;
      end else if (dv_side.neg[k]) begin
        unit_nxt[k] = -pos;
      end else begin
        unit_nxt[k] = pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_r <= unit_nxt;
      mag_r  <= dv_side.zero ? '0 : dv_mag;
      zero_r <= dv_side.zero;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, mag_r, unit_r[2], unit_r[1], unit_r[0]};
  assign out_tuser  = zero_r;

  // A zero-length result carries a zero vector and a zero magnitude.
  `VN_ASSERT(a_zero_fields, out_valid_r && zero_r |-> unit_r == '0 && mag_r == '0)
  // Any other result has a non-zero magnitude.
  `VN_ASSERT(a_nonzero_mag, out_valid_r && !zero_r |-> mag_r != '0)
  // Each unit component lies within plus and minus one.
  `VN_ASSERT(a_unit_range, out_valid_r |-> $signed(unit_r[0]) <= 65536 && $signed(unit_r[0]) >= -65536 && $signed(unit_r[1]) <= 65536 && $signed(unit_r[1]) >= -65536 && $signed(unit_r[2]) <= 65536 && $signed(unit_r[2]) >= -65536)

endmodule

### bench/vec3_normalize_tb.sv
`timescale 1ns / 1ps

module vec3_normalize_tb;

  localparam int LATENCY = 56;

  // Request kinds carried in tuser.
  typedef enum logic {NORM_A = 1'b0, NORM_CROSS = 1'b1} req_kind_t;

  typedef struct packed {
    logic                     zero_length;
    logic [vn_pkg::MAG_W-1:0] magnitude;
    logic [vn_pkg::UNIT_W-1:0] uz;
    logic [vn_pkg::UNIT_W-1:0] uy;
    logic [vn_pkg::UNIT_W-1:0] ux;
  } unit_res_t;

  typedef struct {
    req_kind_t                 kind;
    logic [vn_pkg::IN_W-1:0]   a [3];
    logic [vn_pkg::IN_W-1:0]   b [3];
    logic                      typed;
    unit_res_t                 res;
  } vec_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [87:0]  out_tdata;
  logic         out_tuser;

  unit_res_t expected_units [$];
  int        fail_count = 0;
  bit        calm = 1'b0;
  bit        hold_off = 1'b0;
  bit        sending_done = 1'b0;

  vec3_normalize i_dut (.*);

  // Clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Round-to-nearest integer square root of a sum of squares.
  function automatic longint unsigned isqrt_nearest(longint unsigned s);
    longint unsigned root, bit_v;
    root = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > s) bit_v >>= 2;
    while (bit_v != 0) begin
      if (s >= root + bit_v) begin
        s -= root + bit_v;
        root = (root >> 1) + bit_v;
      end else begin
        root >>= 1;
      end
      bit_v >>= 2;
    end
    if (s > root) root += 1;
    return root;
  endfunction

  // Cross product term in Q.2F, rounded half up to Q.F and clamped to +-2^31.
  function automatic longint cross_term(longint p);
    longint r;
    r = (p + (64'sd1 << (vn_pkg::FRAC_BITS - 1))) >>> vn_pkg::FRAC_BITS;
    if (r > (64'sd1 << 31)) r = 64'sd1 << 31;
    if (r < -(64'sd1 << 31)) r = -(64'sd1 << 31);
    return r;
  endfunction

  // Expected normalised vector and length for one request.
  function automatic unit_res_t normalise(req_kind_t kind, logic [vn_pkg::IN_W-1:0] a [3],
                                          logic [vn_pkg::IN_W-1:0] b [3]);
    longint          av [3], bv [3], c [3];
    longint unsigned sum, m, mag, q;
    logic [vn_pkg::UNIT_W-1:0] u [3];
    unit_res_t       r;
    for (int i = 0; i < 3; i++) begin
      av[i] = longint'(signed'(a[i]));
      bv[i] = longint'(signed'(b[i]));
    end
    if (kind == NORM_CROSS) begin
      c[0] = cross_term(av[1] * bv[2] - av[2] * bv[1]);
      c[1] = cross_term(av[2] * bv[0] - av[0] * bv[2]);
      c[2] = cross_term(av[0] * bv[1] - av[1] * bv[0]);
    end else begin
      c = av;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag = (c[i] < 0) ? -c[i] : c[i];
      sum += mag * mag;
    end
    r = '0;
    if (sum == 0) begin
      r.zero_length = 1'b1;
      return r;
    end
    m = isqrt_nearest(sum);
    for (int i = 0; i < 3; i++) begin
      mag = (c[i] < 0) ? -c[i] : c[i];
      q = ((mag << vn_pkg::FRAC_BITS) + (m >> 1)) / m;
      if (q > (64'd1 << vn_pkg::FRAC_BITS)) q = 64'd1 << vn_pkg::FRAC_BITS;
      if (c[i] < 0) q = -q;
      u[i] = q[vn_pkg::UNIT_W-1:0];
    end
    r.ux = u[0];
    r.uy = u[1];
    r.uz = u[2];
    r.magnitude = (m > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : m[vn_pkg::MAG_W-1:0];
    return r;
  endfunction

  // Offer one item and wait until it is taken; predict it at acceptance.
  task automatic send_vector(req_kind_t kind, logic [vn_pkg::IN_W-1:0] a [3],
                             logic [vn_pkg::IN_W-1:0] b [3], bit typed,
                             unit_res_t typed_res);
    unit_res_t predicted;
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= {b[2], b[1], b[0], a[2], a[1], a[0]};
    in_tuser <= kind;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = normalise(kind, a, b);
    if (typed && predicted != typed_res)
      $error("Predictor disagrees with table row: %h vs %h", predicted, typed_res);
    expected_units.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  // Random component: full range half the time, else small, extreme or near one.
  function automatic logic [vn_pkg::IN_W-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return vn_pkg::IN_W'($urandom_range(0, 8) - 4);
      1: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      2: return vn_pkg::IN_W'(int'($urandom_range(0, 2 << vn_pkg::FRAC_BITS))
                              - (1 << vn_pkg::FRAC_BITS));
      default: return vn_pkg::IN_W'($urandom);
    endcase
  endfunction

  // Stimulus.
  initial begin
    vec_row_t rows [$];
    vec_row_t row;
    logic [vn_pkg::IN_W-1:0] a [3], b [3];
    localparam logic [vn_pkg::IN_W-1:0] MAXP = 24'h7FFFFF;
    localparam logic [vn_pkg::IN_W-1:0] MAXN = 24'h800000;
    localparam logic [vn_pkg::IN_W-1:0] ONE  = 24'h010000;
    localparam logic [vn_pkg::UNIT_W-1:0] U1 = 18'h10000;

    // Directed table; only the obvious rows carry a typed result.
    row = '{NORM_A, '{0, 0, 0}, '{0, 0, 0}, 1, '{1'b1, 32'd0, 18'd0, 18'd0, 18'd0}};
    rows.push_back(row);
    row = '{NORM_A, '{ONE, 0, 0}, '{MAXP, MAXN, 1}, 1, '{1'b0, 32'h10000, 18'd0, 18'd0, U1}};
    rows.push_back(row);
    row = '{NORM_A, '{0, -ONE, 0}, '{0, 0, 0}, 1,
            '{1'b0, 32'h10000, 18'd0, -U1, 18'd0}};
    rows.push_back(row);
    row = '{NORM_A, '{0, 0, MAXN}, '{0, 0, 0}, 1,
            '{1'b0, 32'h800000, -U1, 18'd0, 18'd0}};
    rows.push_back(row);
    row = '{NORM_CROSS, '{ONE, 0, 0}, '{ONE, 0, 0}, 1, '{1'b1, 32'd0, 18'd0, 18'd0, 18'd0}};
    rows.push_back(row);
    row = '{NORM_CROSS, '{ONE, 0, 0}, '{0, ONE, 0}, 1,
            '{1'b0, 32'h10000, U1, 18'd0, 18'd0}};
    rows.push_back(row);
    row = '{NORM_A, '{MAXP, MAXP, MAXP}, '{0, 0, 0}, 0, '0}; rows.push_back(row);
    row = '{NORM_A, '{MAXN, MAXN, MAXN}, '{0, 0, 0}, 0, '0}; rows.push_back(row);
    row = '{NORM_A, '{1, 0, 0}, '{0, 0, 0}, 0, '0}; rows.push_back(row);
    row = '{NORM_A, '{1, 1, 1}, '{0, 0, 0}, 0, '0}; rows.push_back(row);
    row = '{NORM_A, '{24'hFFFFFF, 2, 24'hFFFFFD}, '{0, 0, 0}, 0, '0}; rows.push_back(row);
    // Largest cross products, clamped at small fraction widths.
    row = '{NORM_CROSS, '{MAXN, MAXP, MAXN}, '{MAXP, MAXN, MAXP}, 0, '0};
    rows.push_back(row);
    row = '{NORM_CROSS, '{MAXN, MAXN, 0}, '{MAXP, MAXN, MAXN}, 0, '0}; rows.push_back(row);
    row = '{NORM_CROSS, '{MAXP, 0, MAXP}, '{0, MAXP, MAXN}, 0, '0}; rows.push_back(row);
    // Tiny cross product that rounds to zero.
    row = '{NORM_CROSS, '{1, 0, 0}, '{0, 1, 0}, 0, '0}; rows.push_back(row);
    // Overshoot candidates after rounding of the length.
    row = '{NORM_A, '{3, 4, 0}, '{0, 0, 0}, 0, '0}; rows.push_back(row);
    row = '{NORM_A, '{1, 1, 0}, '{0, 0, 0}, 0, '0}; rows.push_back(row);
    row = '{NORM_CROSS, '{ONE, ONE, 0}, '{0, ONE, ONE}, 0, '0}; rows.push_back(row);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) send_vector(rows[i].kind, rows[i].a, rows[i].b,
                                   rows[i].typed, rows[i].res);

    // Random items; the receiver holds off for a long stretch early on.
    for (int n = 0; n < 950; n++) begin
      if (n == 100) hold_off = 1'b1;
      if (n == 800) calm = 1'b1;
      for (int k = 0; k < 3; k++) begin
        a[k] = rand_comp();
        b[k] = rand_comp();
      end
      if ($urandom_range(0, 15) == 0) a = '{0, 0, 0};
      send_vector(req_kind_t'($urandom_range(0, 1)), a, b, 1'b0, '0);
    end
    in_tvalid <= 1'b0;
    sending_done = 1'b1;
  end

  // Receiver readiness: random stalls, one long hold-off, none near the end.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      if (!calm && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 15);
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Result checking at the rising edge.
  always @(posedge clk) begin
    unit_res_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[85:0]};
      if (expected_units.size() == 0) begin
        $error("Result with nothing expected: %h", got);
        fail_count++;
      end else begin
        want = expected_units.pop_front();
        if (got.ux !== want.ux) begin
          $error("unit_x: expected %h, actual %h", want.ux, got.ux); fail_count++;
        end
        if (got.uy !== want.uy) begin
          $error("unit_y: expected %h, actual %h", want.uy, got.uy); fail_count++;
        end
        if (got.uz !== want.uz) begin
          $error("unit_z: expected %h, actual %h", want.uz, got.uz); fail_count++;
        end
        if (got.magnitude !== want.magnitude) begin
          $error("magnitude: expected %h, actual %h", want.magnitude, got.magnitude);
          fail_count++;
        end
        if (got.zero_length !== want.zero_length) begin
          $error("zero_length: expected %b, actual %b", want.zero_length,
                 got.zero_length);
          fail_count++;
        end
      end
    end
  end

  // End of run: drain, let the pipeline settle, then report.
  initial begin
    wait (sending_done);
    wait (expected_units.size() == 0);
    repeat (2 * LATENCY) @(posedge clk);
    if (fail_count == 0 && expected_units.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
